// ===== src/tick_task_scheduler_table_defines.svh =====
// Assertion macros used by the scheduler table datapath.
`ifndef TICK_TASK_SCHEDULER_TABLE_DEFINES_SVH
`define TICK_TASK_SCHEDULER_TABLE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define TTS_ASSERT(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define TTS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/tts_pkg.sv =====
`timescale 1ns / 1ps

package tts_pkg;

    localparam int DELAY_W     = 16;
    localparam int PERIOD_W    = 16;
    localparam int PEND_W      = 8;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;
    localparam logic [PEND_W-1:0] PEND_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TICK     = 2'd2,
        OP_DISPATCH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_FULL       = 2'd1,
        STS_EMPTY      = 2'd2,
        STS_NONE_READY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DEL,
        S_READ,
        S_EXEC,
        S_NONE
    } state_t;

    typedef struct packed {
        logic [DELAY_W-1:0]  delay;
        logic [PERIOD_W-1:0] period;
        logic [PEND_W-1:0]   pending;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic load;
        logic add_go;
        logic del_go;
        logic rd_go;
        logic tick_go;
        logic disp_go;
        logic skip_go;
        logic none_go;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic out_free;
        logic slot_pending;
        logic scan_last;
        logic disp_last;
        logic any_emitted;
    } dp_sts_t;

endpackage

// ===== src/tts_in_if.sv =====
`timescale 1ns / 1ps

interface tts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [2:0]  slot_index;
    logic [15:0] start_delay;
    logic [15:0] repeat_period;

    modport source (output valid, output operation, output slot_index,
                    output start_delay, output repeat_period, input ready);
    modport sink   (input valid, input operation, input slot_index,
                    input start_delay, input repeat_period, output ready);
endinterface

// ===== src/tts_out_if.sv =====
`timescale 1ns / 1ps

interface tts_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] task_slot;
    logic [1:0] status;
    logic       last_result;

    modport source (output valid, output task_slot, output status,
                    output last_result, input ready);
    modport sink   (input valid, input task_slot, input status,
                    input last_result, output ready);
endinterface

// ===== src/tick_task_scheduler_table.sv =====
`timescale 1ns / 1ps
// Tick-driven cooperative task scheduler table.
// Input channel in_ch carries one command per transaction: add a task (takes the
// lowest free slot), delete a slot, tick (age every task in use) or dispatch
// (emit every slot with a pending run, in slot order, at most eight per command).
// Output channel out_ch carries result transactions; last_result marks the final
// result of a command. A tick produces no result.
// One command is in work at a time; in_ch.ready is high only while the block is
// idle. Add and delete load their result once the output register is free and
// free the block for the next command in that same cycle. Tick and dispatch
// walk the slot table through a memory with one write port and a registered
// read port, in a read state and an execute state per slot; a tick visits
// every slot. A dispatch ends right after the last slot with a pending run or
// after its eighth run; one that finds no run reports that none is ready.
// Results leave through an output register, so the next command is accepted
// while the last result of the previous one still waits on out_ch. A stalled
// receiver holds a dispatch scan at the slot whose run waits for the register.
// Reset clears every in-use mark and every pending-run flag at once; the table
// memory needs no clearing pass because a free slot is always rewritten on add.
module tick_task_scheduler_table import tts_pkg::*; #(
    parameter int TASK_SLOTS = 8
) (
    input logic         clk,
    input logic         rst_n,
    tts_in_if.sink      in_ch,
    tts_out_if.source   out_ch
);

    // Command and status bundles between the sequencer and the datapath.
    dp_cmd_t cmd;
    dp_sts_t sts;

    // The sequencer decodes the operation straight off the channel when it
    // accepts a transaction, so decode needs no state of its own.
    tts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_op    (op_t'(in_ch.operation)),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // The datapath owns the slot table, the scan counter, and the output
    // register that decouples the result channel from the sequencer.
    tts_dp #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .operation     (in_ch.operation),
        .slot_index    (in_ch.slot_index),
        .start_delay   (in_ch.start_delay),
        .repeat_period (in_ch.repeat_period),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .task_slot     (out_ch.task_slot),
        .status        (out_ch.status),
        .last_result   (out_ch.last_result)
    );

endmodule

// ===== src/tts_ram.sv =====
`timescale 1ns / 1ps

module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tts_ctrl.sv =====
`timescale 1ns / 1ps

module tts_ctrl import tts_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  op_t     in_op,
    output logic    in_ready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (in_op)
                        OP_ADD:    state_next = S_ADD;
                        OP_DELETE: state_next = S_DEL;
                        default:   state_next = S_READ;
                    endcase
                end
            end
            S_ADD:
            begin
                if (sts.out_free)
                begin
                    cmd.add_go = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DEL:
            begin
                if (sts.out_free)
                begin
                    cmd.del_go = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.rd_go  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.op == OP_TICK)
                begin
                    cmd.tick_go = 1'b1;
                    state_next  = sts.scan_last ? S_IDLE : S_READ;
                end
                else if (sts.slot_pending)
                begin
                    // Hold here until the output register can take the run.
                    if (sts.out_free)
                    begin
                        cmd.disp_go = 1'b1;
                        state_next  = sts.disp_last ? S_IDLE : S_READ;
                    end
                end
                else
                begin
                    cmd.skip_go = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = sts.any_emitted ? S_IDLE : S_NONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_NONE:
            begin
                if (sts.out_free)
                begin
                    cmd.none_go = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/tts_dp.sv =====
`timescale 1ns / 1ps
`include "tick_task_scheduler_table_defines.svh"

module tts_dp import tts_pkg::*; #(
    parameter int TASK_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  operation,
    input  logic [2:0]  slot_index,
    input  logic [15:0] start_delay,
    input  logic [15:0] repeat_period,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  task_slot,
    output logic [1:0]  status,
    output logic        last_result
);

    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    op_t                 op_reg;
    logic [2:0]          del_idx_reg;
    logic [DELAY_W-1:0]  dly_reg;
    logic [PERIOD_W-1:0] per_reg;

    logic [SLOT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [TASK_SLOTS-1:0] used_reg;
    logic [TASK_SLOTS-1:0] pend_nz_reg;

    logic          out_valid_reg;
    logic [2:0]    out_slot_reg;
    status_t       out_status_reg;
    logic          out_last_reg;

    logic          out_free;
    logic          out_load;
    logic [2:0]    out_slot_next;
    status_t       out_status_next;
    logic          out_last_next;

    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [TASK_SLOTS-1:0] above_mask;
    logic              disp_last;
    logic              scan_last;

    logic [SLOT_W-1:0] del_addr;
    logic              del_in_range;
    logic              del_hit;

    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;
    entry_t             tick_entry;
    entry_t             disp_entry;
    logic               cur_used;
    logic               disp_keep;

    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    entry_t             ram_wdata;

    tts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TASK_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_go),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Lowest free slot for an add.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Slots past the current scan position.
    always_comb
    begin
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            above_mask[i] = (SLOT_W'(i) > idx_reg);
        end
    end

    assign scan_last = (idx_reg == SLOT_W'(TASK_SLOTS - 1));
    assign disp_last = ((pend_nz_reg & above_mask) == '0) ||
                       (cnt_reg == CNT_W'(MAX_RESULTS - 1));

    assign del_addr     = SLOT_W'(del_idx_reg);
    assign del_in_range = (int'(del_idx_reg) < TASK_SLOTS);
    assign del_hit      = del_in_range && used_reg[del_addr];

    assign rd_entry = entry_t'(ram_rdata);
    assign cur_used = used_reg[idx_reg];

    always_comb
    begin
        tick_entry = rd_entry;
        if (rd_entry.delay == '0)
        begin
            if (rd_entry.pending != PEND_MAX)
            begin
                tick_entry.pending = rd_entry.pending + PEND_W'(1);
            end
            if (rd_entry.period != '0)
            begin
                tick_entry.delay = rd_entry.period;
            end
        end
        else
        begin
            tick_entry.delay = rd_entry.delay - DELAY_W'(1);
        end
    end

    always_comb
    begin
        disp_entry         = rd_entry;
        disp_entry.pending = rd_entry.pending - PEND_W'(1);
    end

    // A one-shot task is freed by dropping its in-use mark after its run.
    assign disp_keep = (rd_entry.period != '0);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = tick_entry;
        if (cmd.add_go)
        begin
            ram_we    = free_found;
            ram_waddr = free_idx;
            ram_wdata = '{delay: dly_reg, period: per_reg, pending: '0};
        end
        else if (cmd.tick_go)
        begin
            ram_we = cur_used;
        end
        else if (cmd.disp_go)
        begin
            ram_we    = disp_keep;
            ram_wdata = disp_entry;
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = cmd.add_go || cmd.del_go || cmd.disp_go || cmd.none_go;

    always_comb
    begin
        out_slot_next   = '0;
        out_status_next = STS_NONE_READY;
        out_last_next   = 1'b1;
        if (cmd.add_go)
        begin
            out_slot_next   = free_found ? 3'(free_idx) : 3'd0;
            out_status_next = free_found ? STS_OK : STS_FULL;
        end
        else if (cmd.del_go)
        begin
            out_slot_next   = del_idx_reg;
            out_status_next = del_hit ? STS_OK : STS_EMPTY;
        end
        else if (cmd.disp_go)
        begin
            out_slot_next   = 3'(idx_reg);
            out_status_next = STS_OK;
            out_last_next   = disp_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op_t'(operation);
            del_idx_reg <= slot_index;
            dly_reg     <= start_delay;
            per_reg     <= repeat_period;
        end
        if (out_load)
        begin
            out_slot_reg   <= out_slot_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= '0;
            used_reg      <= '0;
            pend_nz_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
                cnt_reg <= '0;
            end
            else if (cmd.tick_go || cmd.skip_go || cmd.disp_go)
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
            if (cmd.disp_go)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            if (cmd.add_go && free_found)
            begin
                used_reg[free_idx]    <= 1'b1;
                pend_nz_reg[free_idx] <= 1'b0;
            end
            if (cmd.del_go && del_in_range)
            begin
                used_reg[del_addr]    <= 1'b0;
                pend_nz_reg[del_addr] <= 1'b0;
            end
            if (cmd.tick_go && cur_used)
            begin
                pend_nz_reg[idx_reg] <= (tick_entry.pending != '0);
            end
            if (cmd.disp_go)
            begin
                used_reg[idx_reg]    <= disp_keep;
                pend_nz_reg[idx_reg] <= disp_keep && (disp_entry.pending != '0);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.op           = op_reg;
    assign sts.out_free     = out_free;
    assign sts.slot_pending = pend_nz_reg[idx_reg];
    assign sts.scan_last    = scan_last;
    assign sts.disp_last    = disp_last;
    assign sts.any_emitted  = (cnt_reg != '0);

    assign out_valid   = out_valid_reg;
    assign task_slot   = out_slot_reg;
    assign status      = out_status_reg;
    assign last_result = out_last_reg;

    `TTS_ASSERT(a_pend_only_in_use, clk, rst_n, (pend_nz_reg & ~used_reg) == '0,
        "pending run recorded on a free slot")
    `TTS_ASSERT(a_disp_count_bound, clk, rst_n, cnt_reg <= CNT_W'(MAX_RESULTS),
        "dispatch emitted more runs than allowed")
    `TTS_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_load, out_free,
        "output register loaded while a transaction still waits")
    `TTS_ASSERT_IMP(a_disp_has_run, clk, rst_n, cmd.disp_go, pend_nz_reg[idx_reg],
        "dispatched a slot without a pending run")

endmodule
